@@ sv/srp_pkg.sv @@
`default_nettype none

package srp_pkg;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 31;
    localparam int COUNT_W  = 13;
    localparam int PICK_W   = 12;
    localparam int TOTAL_W  = 32;

    localparam int TABLE_DEPTH = 56;

    localparam logic [KIND_W-1:0] KIND_LOAD_SLOT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_INDEX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW       = 2'd2;

    localparam logic [POS_W:0]   INDEX_END   = 7'h38;
    localparam logic [POS_W-1:0] NEAR_LIMIT  = 6'h22;
    localparam logic [POS_W-1:0] STEP_AHEAD  = 6'h15;
    localparam logic [POS_W-1:0] STEP_BACK   = 6'h22;
    localparam logic [POS_W-1:0] FIRST_INDEX = 6'd1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] slot_value;
        logic [COUNT_W-1:0] count;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] raw_value;
        logic [PICK_W-1:0]  pick;
        logic               no_pick;
        logic [TOTAL_W-1:0] draw_total;
    } t_out;

endpackage

`default_nettype wire

@@ sv/srp_ram.sv @@
`default_nettype none

module srp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 56
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/subtractive_random_pick_core.sv @@
// Sequence: a nonzero-count draw goes through a slot read, a subtract-and-store, 31
//   remainder steps and an output load that waits while a pending result is stalled.
// Draw length is set by the bit-serial restoring remainder unit; no new transaction is
//   taken until it ends. Loads keep it idle; a zero-count draw skips to the output load.
// Reset (i_rst_n low, synchronous): running index and draw counter clear, no result
//   pending. Table slots hold no reset value and must be loaded before use.
`default_nettype none

module subtractive_random_pick_core import srp_pkg::*; #(
    parameter int MAX_CANDIDATES = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_item,
    output      logic o_stall,
    output      logic o_valid,
    output      t_out o_result,
    input  wire logic i_stall
);

    localparam int CAP = (MAX_CANDIDATES < (1 << COUNT_W)) ? MAX_CANDIDATES
                                                           : (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);
    localparam logic [4:0] LAST_BIT = 5'(VALUE_W - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_CALC  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [POS_W-1:0]     r_run_index, n_run_index;
    logic [TOTAL_W-1:0]   r_draw_cnt, n_draw_cnt;
    logic                 r_zero, n_zero;
    logic                 r_out_valid, n_out_valid;
    logic [POS_W-1:0]     r_cur, n_cur;
    logic [POS_W-1:0]     r_part, n_part;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [VALUE_W-1:0]   r_a, n_a;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [VALUE_W-1:0]   r_quot, n_quot;
    logic [COUNT_W-1:0]   r_rem, n_rem;
    logic [4:0]           r_bit, n_bit;
    t_out                 r_out, n_out;

    logic                 w_accept;
    logic [POS_W:0]       w_inc;
    logic [POS_W-1:0]     w_cur;
    logic [POS_W-1:0]     w_part;
    logic [COUNT_W-1:0]   w_count;
    logic [VALUE_W-1:0]   w_rdata;
    logic                 w_ge;
    logic [VALUE_W-1:0]   w_diff;
    logic [COUNT_W:0]     w_trial;
    logic [COUNT_W:0]     w_trial_sub;
    logic                 w_fit;
    logic                 w_we;
    logic [POS_W-1:0]     w_waddr;
    logic [VALUE_W-1:0]   w_wdata;
    logic [POS_W-1:0]     w_raddr;
    logic                 w_out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    // next slot and its partner, 21 ahead or 34 behind
    assign w_inc  = {1'b0, r_run_index} + (POS_W+1)'(1);
    assign w_cur  = (w_inc < INDEX_END) ? w_inc[POS_W-1:0] : FIRST_INDEX;
    assign w_part = (w_cur > NEAR_LIMIT) ? (w_cur - STEP_BACK) : (w_cur + STEP_AHEAD);

    assign w_count = (i_item.count > CAP_V) ? CAP_V : i_item.count;

    // current minus partner, wrapped into the 31-bit range by adding 2^31-1
    assign w_ge   = (r_a >= w_rdata);
    assign w_diff = r_a + ~w_rdata + VALUE_W'(w_ge);

    // one restoring remainder step per cycle, most significant bit first
    assign w_trial     = {r_rem, r_quot[VALUE_W-1]};
    assign w_fit       = (w_trial >= {1'b0, r_count});
    assign w_trial_sub = w_trial - {1'b0, r_count};

    assign w_raddr = (r_state == S_IDLE) ? w_cur : r_part;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_item.position;
        w_wdata = i_item.slot_value;
        if (r_state == S_CALC) begin
            w_we    = 1'b1;
            w_waddr = r_cur;
            w_wdata = w_diff;
        end else if (w_accept && i_item.kind == KIND_LOAD_SLOT
                     && i_item.position < POS_W'(TABLE_DEPTH)) begin
            w_we = 1'b1;
        end
    end

    srp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_run_index = r_run_index;
        n_draw_cnt  = r_draw_cnt;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_stall;
        n_cur       = r_cur;
        n_part      = r_part;
        n_count     = r_count;
        n_a         = r_a;
        n_value     = r_value;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (i_item.kind == KIND_LOAD_INDEX) begin
                        n_run_index = i_item.position;
                    end else if (i_item.kind == KIND_DRAW) begin
                        if (i_item.count == '0) begin
                            n_zero  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_run_index = w_cur;
                            n_cur       = w_cur;
                            n_part      = w_part;
                            n_count     = w_count;
                            n_state     = S_FETCH;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                // current slot arrives now, partner read goes out
                n_a     = w_rdata;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_value    = w_diff;
                n_quot     = w_diff;
                n_rem      = '0;
                n_bit      = LAST_BIT;
                n_draw_cnt = r_draw_cnt + TOTAL_W'(1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_fit ? w_trial_sub[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
                n_quot = {r_quot[VALUE_W-2:0], 1'b0};
                n_bit  = r_bit - 5'd1;
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register can take the transaction
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.raw_value  = r_zero ? '0 : r_value;
                    n_out.pick       = r_zero ? '0 : r_rem[PICK_W-1:0];
                    n_out.no_pick    = r_zero;
                    n_out.draw_total = r_draw_cnt;
                    n_zero           = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_index <= '0;
            r_draw_cnt  <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_index <= n_run_index;
            r_draw_cnt  <= n_draw_cnt;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_part  <= n_part;
        r_count <= n_count;
        r_a     <= n_a;
        r_value <= n_value;
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_out   <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

@@ sv/srp_checker.sv @@
`default_nettype none

module srp_checker import srp_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire t_in  i_item,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire t_out o_result,
    input wire logic i_stall
);

    // a pending result holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending right after reset");

    a_no_pick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.no_pick |-> o_result.raw_value == '0 && o_result.pick == '0)
        else $error("zero-count transaction carries a value");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.kind == KIND_DRAW |=> o_stall)
        else $error("draw transaction did not occupy the block");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.kind != KIND_DRAW |=> !o_stall)
        else $error("load transaction left the block busy");

endmodule

bind subtractive_random_pick_core srp_checker u_srp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .i_item   (i_item),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .o_result (o_result),
    .i_stall  (i_stall)
);

`default_nettype wire
